// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/sbf_pkg.sv -----
// ----------------------------------------------------------------------------
// sbf_pkg
// Types, constants and the escape helper of the SLIP block framer.
// ----------------------------------------------------------------------------
package sbf_pkg;

  localparam int unsigned SBF_QUEUE_DEPTH = 2;

  localparam logic [7:0] END_CODE_RST    = 8'd192;
  localparam logic [7:0] ESC_CODE_RST    = 8'd219;
  localparam logic [7:0] ESC_END_RST     = 8'd220;
  localparam logic [7:0] ESC_ESC_RST     = 8'd221;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_DATA  = 1'b1;

  typedef enum logic [1:0] {
    REG_END_CODE    = 2'd0,
    REG_ESC_CODE    = 2'd1,
    REG_ESC_END     = 2'd2,
    REG_ESC_ESC     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] end_code;
    logic [7:0] escape_code;
    logic [7:0] escaped_end_code;
    logic [7:0] escaped_escape_code;
  } cfg_t;

  // One escaped byte: one or two bytes on the line.
  typedef struct packed {
    logic       len2;
    logic [7:0] b0;
    logic [7:0] b1;
  } seg_t;

  // All line bytes caused by one input transaction.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            done;
  } entry_t;

  function automatic seg_t escape_byte(input logic [7:0] b, input cfg_t cfg);
    seg_t s;
    s.len2 = 1'b1;
    s.b0   = cfg.escape_code;
    s.b1   = cfg.escaped_end_code;
    if (b == cfg.end_code) begin
      s.b1 = cfg.escaped_end_code;
    end else if (b == cfg.escape_code) begin
      s.b1 = cfg.escaped_escape_code;
    end else begin
      s.len2 = 1'b0;
      s.b0   = b;
    end
    return s;
  endfunction

endpackage

// ----- rtl/sbf_front.sv -----
// ----------------------------------------------------------------------------
// sbf_front
// Accepts input transactions, tracks the open block and builds line bytes.
// ----------------------------------------------------------------------------
module sbf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           mode_i,
  input  logic [7:0]     value_i,
  input  sbf_pkg::cfg_t  cfg_i,
  input  logic           q_full_i,
  output logic           in_stall_o,
  output logic           push_o,
  output sbf_pkg::entry_t entry_o
);
  import sbf_pkg::*;

  logic [7:0] remaining_q, remaining_d;
  logic [7:0] sum_q, sum_d;
  logic       open_q, open_d;

  logic       accept;
  logic [7:0] sum_next, rem_next;
  seg_t       seg_a, seg_ck, seg_val;
  logic       need_ck;
  logic [2:0] len_a, len_b, total;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign sum_next = sum_q + value_i;
  assign rem_next = remaining_q - 8'd1;
  assign seg_val  = escape_byte(value_i, cfg_i);

  always_comb begin
    remaining_d = remaining_q;
    sum_d       = sum_q;
    open_d      = open_q;
    push_o      = 1'b0;
    if (mode_i == MODE_START) begin
      seg_a   = '{len2: 1'b1, b0: cfg_i.end_code, b1: value_i};
      need_ck = (value_i == 8'd0);
      seg_ck  = seg_val;    // checksum of an empty block equals its length
    end else begin
      seg_a   = seg_val;
      need_ck = (rem_next == 8'd0);
      seg_ck  = escape_byte(sum_next, cfg_i);
    end
    if (accept) begin
      if (mode_i == MODE_START) begin
        push_o      = 1'b1;
        remaining_d = value_i;
        sum_d       = value_i;
        open_d      = !need_ck;
      end else if (open_q) begin
        push_o      = 1'b1;
        remaining_d = rem_next;
        sum_d       = sum_next;
        open_d      = !need_ck;
      end
    end
    len_a = seg_a.len2 ? 3'd2 : 3'd1;
    len_b = !need_ck ? 3'd0 : (seg_ck.len2 ? 3'd2 : 3'd1);
    total = len_a + len_b;
    entry_o.bytes[0] = seg_a.b0;
    entry_o.bytes[1] = seg_a.len2 ? seg_a.b1 : seg_ck.b0;
    entry_o.bytes[2] = seg_a.len2 ? seg_ck.b0 : seg_ck.b1;
    entry_o.bytes[3] = seg_ck.b1;
    entry_o.last_idx = 2'(total - 3'd1);
    entry_o.done     = need_ck;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
      sum_q       <= '0;
      open_q      <= 1'b0;
    end else begin
      remaining_q <= remaining_d;
      sum_q       <= sum_d;
      open_q      <= open_d;
    end
  end

endmodule

// ----- rtl/sbf_queue.sv -----
// ----------------------------------------------------------------------------
// sbf_queue
// Small FIFO of byte groups between the front and the back end.
// ----------------------------------------------------------------------------
module sbf_queue #(
  parameter int unsigned Depth = sbf_pkg::SBF_QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sbf_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output sbf_pkg::entry_t head_o,
  output logic            empty_o
);
  import sbf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- rtl/sbf_back.sv -----
// ----------------------------------------------------------------------------
// sbf_back
// Sends the queued byte groups one byte per transaction on the output.
// ----------------------------------------------------------------------------
module sbf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sbf_pkg::entry_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            last_o,
  output logic            frame_done_o
);
  import sbf_pkg::*;

  entry_t     cur_q, cur_d;
  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic       fire, is_last;

  assign out_valid_o  = valid_q;
  assign out_byte_o   = cur_q.bytes[idx_q];
  assign is_last      = (idx_q == cur_q.last_idx);
  assign last_o       = is_last;
  assign frame_done_o = is_last && cur_q.done;
  assign fire         = valid_q && !out_stall_i;

  always_comb begin
    cur_d   = cur_q;
    idx_d   = idx_q;
    valid_d = valid_q;
    pop_o   = 1'b0;
    if (!valid_q || (fire && is_last)) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        pop_o = 1'b1;
        cur_d = head_i;
        idx_d = '0;
      end
    end else if (fire) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

// ----- rtl/slip_block_framer_core.sv -----
// A transaction's first line byte is written into the queue, then loaded into the back end's output register.
// Throughput: one line byte per cycle, set by the single-byte output port, unless
// out_stall_i is high or the queue is empty; the front takes bursts until the queue fills.
// Reset: asynchronous, active low; codes return to defaults, no block open, queue empty.
// ----------------------------------------------------------------------------
// slip_block_framer_core
// SLIP framer with raw length byte and escaped 8-bit additive checksum.
// ----------------------------------------------------------------------------
module slip_block_framer_core #(
  parameter int unsigned QueueDepth = sbf_pkg::SBF_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic        frame_done_o
);
  import sbf_pkg::*;

`include "assert_macros.svh"

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e reg_sel;
  logic     cfg_wr;
  logic     q_push, q_full, q_pop, q_empty;
  entry_t   q_in, q_head;
  logic     in_start;

  assign pready   = 1'b1;
  assign reg_sel  = cfg_reg_e'(paddr[3:2]);
  assign cfg_wr   = psel && penable && pwrite;
  assign in_start = in_valid_i && !in_stall_o && (mode_i == MODE_START);

  always_comb begin
    cfg_d  = cfg_q;
    prdata = '0;
    unique case (reg_sel)
      REG_END_CODE: begin
        prdata[7:0] = cfg_q.end_code;
        if (cfg_wr) cfg_d.end_code = pwdata[7:0];
      end
      REG_ESC_CODE: begin
        prdata[7:0] = cfg_q.escape_code;
        if (cfg_wr) cfg_d.escape_code = pwdata[7:0];
      end
      REG_ESC_END: begin
        prdata[7:0] = cfg_q.escaped_end_code;
        if (cfg_wr) cfg_d.escaped_end_code = pwdata[7:0];
      end
      REG_ESC_ESC: begin
        prdata[7:0] = cfg_q.escaped_escape_code;
        if (cfg_wr) cfg_d.escaped_escape_code = pwdata[7:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{end_code: END_CODE_RST, escape_code: ESC_CODE_RST,
                 escaped_end_code: ESC_END_RST, escaped_escape_code: ESC_ESC_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sbf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .value_i    (value_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (q_push),
    .entry_o    (q_in)
  );

  sbf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  sbf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .empty_i      (q_empty),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o),
    .frame_done_o (frame_done_o)
  );

  `ASSERT_ON(a_done_is_last, out_valid_o && frame_done_o |-> last_o, "frame_done without last")
  `ASSERT_ON(a_no_push_full, q_push |-> !q_full, "push into full queue")
  `ASSERT_ON(a_start_queued, in_start |=> !q_empty || out_valid_o, "start transaction lost")
  `ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "output valid in reset")

endmodule
